>>> rtl/core/ata_pio_command_issuer_unit_assert.svh
// assertion macros shared by the rtl, compiled out for synthesis
`ifndef ATA_PIO_COMMAND_ISSUER_UNIT_ASSERT_SVH
`define ATA_PIO_COMMAND_ISSUER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// checked at every rising clock edge, reset included
`define APCI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
// checked outside reset only
`define APCI_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define APCI_ASSERT_ALWAYS(label, clk, prop, msg)
`define APCI_ASSERT_RUN(label, clk, rst_n, prop, msg)
`endif

`endif

>>> rtl/core/apci_pkg.sv
// types and constants of the ata pio command issuer
package apci_pkg;

    localparam int DELAY_READS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    // config port
    localparam int APB_AW = 4;
    localparam logic [1:0] REG_CMD_BASE = 2'd0;
    localparam logic [1:0] REG_CTL_BASE = 2'd1;
    localparam logic [1:0] REG_NIEN     = 2'd2;

    localparam logic [15:0] CMD_BASE_RST = 16'h01F0;
    localparam logic [15:0] CTL_BASE_RST = 16'h03F6;

    // task file register offsets
    localparam logic [15:0] OFS_COUNT = 16'd2;
    localparam logic [15:0] OFS_LBA_L = 16'd3;
    localparam logic [15:0] OFS_LBA_M = 16'd4;
    localparam logic [15:0] OFS_LBA_H = 16'd5;
    localparam logic [15:0] OFS_SEL   = 16'd6;
    localparam logic [15:0] OFS_CMD   = 16'd7;

    localparam logic [7:0] SEL_MASTER = 8'hE0;
    localparam logic [7:0] SEL_SLAVE  = 8'hF0;
    localparam logic [7:0] CMD_RD28   = 8'h20;
    localparam logic [7:0] CMD_RD48   = 8'h24;
    localparam logic [7:0] CMD_WR28   = 8'h30;
    localparam logic [7:0] CMD_WR48   = 8'h34;
    localparam logic [7:0] CTL_NIEN   = 8'h02;
    localparam logic [7:0] CTL_IEN    = 8'h00;

    localparam int         LBA28_BITS = 28;
    localparam logic [8:0] MAX_COUNT  = 9'd256;

    // access positions in the full lba48 sequence; lba28 skips the high part
    localparam int P_SEL    = 0;
    localparam int P_CNT_HI = 1;
    localparam int P_LBA3   = 2;
    localparam int P_LBA4   = 3;
    localparam int P_LBA5   = 4;
    localparam int P_CNT_LO = 5;
    localparam int P_LBA0   = 6;
    localparam int P_LBA1   = 7;
    localparam int P_LBA2   = 8;
    localparam int P_CTL    = 9;
    localparam int P_DLY    = 10;

    typedef struct packed {
        logic        drive_select;
        logic [47:0] start_lba;
        logic [8:0]  sector_count;
        logic        is_write;
    } t_req;

    typedef struct packed {
        logic [15:0] port_address;
        logic        access_is_write;
        logic [7:0]  byte_value;
        logic        last_access;
        logic        count_error;
    } t_acc;

    // classified request held in the queue
    typedef struct packed {
        logic        err;
        logic        ext;
        logic [7:0]  sel_byte;
        logic [7:0]  cmd_byte;
        logic [47:0] lba;
        logic [8:0]  count;
    } t_desc;

    typedef struct packed {
        logic [15:0] cmd_base;
        logic [15:0] ctl_base;
        logic        nien;
    } t_cfg;

endpackage

>>> rtl/core/apci_if.sv
// request and bus access channels
interface apci_req_if import apci_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface apci_acc_if import apci_pkg::*; ();
    logic valid;
    logic ready;
    t_acc data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/apci_front.sv
// front end: accepts requests and classifies them for the queue
module apci_front import apci_pkg::*; (
    apci_req_if.sink  i_req,
    output logic      o_push_valid,
    output t_desc     o_push_desc,
    input  logic      i_push_ready
);

    always_comb begin
        o_push_desc.err = (i_req.data.sector_count == '0) ||
                          (i_req.data.sector_count > MAX_COUNT);
        o_push_desc.ext = |i_req.data.start_lba[47:LBA28_BITS];
        o_push_desc.sel_byte = i_req.data.drive_select ? SEL_SLAVE : SEL_MASTER;
        unique case ({o_push_desc.ext, i_req.data.is_write})
            2'b00:   o_push_desc.cmd_byte = CMD_RD28;
            2'b01:   o_push_desc.cmd_byte = CMD_WR28;
            2'b10:   o_push_desc.cmd_byte = CMD_RD48;
            default: o_push_desc.cmd_byte = CMD_WR48;
        endcase
        o_push_desc.lba   = i_req.data.start_lba;
        o_push_desc.count = i_req.data.sector_count;
    end

    assign o_push_valid = i_req.valid;
    assign i_req.ready  = i_push_ready;

endmodule

>>> rtl/core/apci_queue.sv
// short fifo of classified requests between front and back
module apci_queue import apci_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    input  t_desc i_push_desc,
    output logic  o_push_ready,
    output logic  o_head_valid,
    output t_desc o_head_desc,
    input  logic  i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_desc  = r_mem[r_rd_ptr];
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_desc;
        end
    end

endmodule

>>> rtl/core/apci_back.sv
// back end: walks the access sequence of the head request, one access per cycle while the output is not held
module apci_back import apci_pkg::*; #(
    parameter int DELAY_READS = DELAY_READS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_head_valid,
    input  t_desc      i_head_desc,
    output logic       o_pop,
    apci_acc_if.source o_acc
);

    localparam int CMD_POS = P_DLY + DELAY_READS;
    localparam int POS_W   = $clog2(CMD_POS + 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_out_valid;
    t_acc             r_out, n_acc;
    logic             advance, take, done;

    assign advance = !r_out_valid || o_acc.ready;
    assign take    = i_head_valid && advance;
    assign done    = i_head_desc.err || (r_pos == POS_W'(CMD_POS));
    assign o_pop   = take && done;

    // lba28 jumps from the select write straight to the low count
    assign n_pos = (r_pos == POS_W'(P_SEL) && !i_head_desc.ext) ?
                   POS_W'(P_CNT_LO) : r_pos + 1'b1;

    always_comb begin
        n_acc.access_is_write = 1'b1;
        n_acc.last_access     = 1'b0;
        n_acc.count_error     = 1'b0;
        n_acc.port_address    = i_cfg.cmd_base;
        n_acc.byte_value      = '0;
        unique case (r_pos)
            POS_W'(P_SEL): begin
                n_acc.port_address = i_cfg.cmd_base + OFS_SEL;
                n_acc.byte_value   = i_head_desc.ext ? i_head_desc.sel_byte :
                                     (i_head_desc.sel_byte | i_head_desc.lba[31:24]);
            end
            POS_W'(P_CNT_HI): begin
                n_acc.port_address = i_cfg.cmd_base + OFS_COUNT;
                n_acc.byte_value   = {7'd0, i_head_desc.count[8]};
            end
            POS_W'(P_LBA3): begin
                n_acc.port_address = i_cfg.cmd_base + OFS_LBA_L;
                n_acc.byte_value   = i_head_desc.lba[31:24];
            end
            POS_W'(P_LBA4): begin
                n_acc.port_address = i_cfg.cmd_base + OFS_LBA_M;
                n_acc.byte_value   = i_head_desc.lba[39:32];
            end
            POS_W'(P_LBA5): begin
                n_acc.port_address = i_cfg.cmd_base + OFS_LBA_H;
                n_acc.byte_value   = i_head_desc.lba[47:40];
            end
            POS_W'(P_CNT_LO): begin
                n_acc.port_address = i_cfg.cmd_base + OFS_COUNT;
                n_acc.byte_value   = i_head_desc.count[7:0];
            end
            POS_W'(P_LBA0): begin
                n_acc.port_address = i_cfg.cmd_base + OFS_LBA_L;
                n_acc.byte_value   = i_head_desc.lba[7:0];
            end
            POS_W'(P_LBA1): begin
                n_acc.port_address = i_cfg.cmd_base + OFS_LBA_M;
                n_acc.byte_value   = i_head_desc.lba[15:8];
            end
            POS_W'(P_LBA2): begin
                n_acc.port_address = i_cfg.cmd_base + OFS_LBA_H;
                n_acc.byte_value   = i_head_desc.lba[23:16];
            end
            POS_W'(P_CTL): begin
                n_acc.port_address = i_cfg.ctl_base;
                n_acc.byte_value   = i_cfg.nien ? CTL_NIEN : CTL_IEN;
            end
            default: begin
                if (r_pos == POS_W'(CMD_POS)) begin
                    n_acc.port_address = i_cfg.cmd_base + OFS_CMD;
                    n_acc.byte_value   = i_head_desc.cmd_byte;
                    n_acc.last_access  = 1'b1;
                end else begin
                    // alternate status read used as a settle delay
                    n_acc.port_address    = i_cfg.ctl_base;
                    n_acc.access_is_write = 1'b0;
                end
            end
        endcase
        if (i_head_desc.err) begin
            n_acc.port_address    = '0;
            n_acc.access_is_write = 1'b0;
            n_acc.byte_value      = '0;
            n_acc.last_access     = 1'b1;
            n_acc.count_error     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= i_head_valid;
            end
            if (take) begin
                r_pos <= done ? '0 : n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_acc;
        end
    end

    assign o_acc.valid = r_out_valid;
    assign o_acc.data  = r_out;

endmodule

>>> rtl/core/ata_pio_command_issuer_unit.sv
// top level of the ata pio command issuer: config registers, front, queue, back
//
//  channel   dir   handshake            content
//  i_req     in    valid/ready          drive, start lba, sector count, direction
//  o_acc     out   valid/ready          one task file bus access per transfer
//  apb       in    psel/penable/pwrite  command base, control base, nien
//
// a request yields 7 + DELAY_READS accesses for lba28, 11 + DELAY_READS for lba48
// and one error transfer for a bad count (11 / 15 / 1 at the default); the back end
// issues one access per cycle while the output is not held.
// the queue lets the next requests be taken while the back end is busy;
// the output register holds an access until it is taken.
// reset is synchronous and clears the queue, the sequence position and the registers.
`include "ata_pio_command_issuer_unit_assert.svh"

module ata_pio_command_issuer_unit import apci_pkg::*; #(
    parameter int DELAY_READS = DELAY_READS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    apci_req_if.sink          i_req,
    apci_acc_if.source        o_acc,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg  r_cfg;
    logic  push_valid, push_ready, head_valid, pop;
    t_desc push_desc, head_desc;
    logic  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cmd_base <= CMD_BASE_RST;
            r_cfg.ctl_base <= CTL_BASE_RST;
            r_cfg.nien     <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_CMD_BASE: r_cfg.cmd_base <= pwdata[15:0];
                REG_CTL_BASE: r_cfg.ctl_base <= pwdata[15:0];
                REG_NIEN:     r_cfg.nien     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CMD_BASE: prdata = {16'd0, r_cfg.cmd_base};
            REG_CTL_BASE: prdata = {16'd0, r_cfg.ctl_base};
            REG_NIEN:     prdata = {31'd0, r_cfg.nien};
            default:      prdata = '0;
        endcase
    end

    apci_front u_front (
        .i_req        (i_req),
        .o_push_valid (push_valid),
        .o_push_desc  (push_desc),
        .i_push_ready (push_ready)
    );

    apci_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_desc  (push_desc),
        .o_push_ready (push_ready),
        .o_head_valid (head_valid),
        .o_head_desc  (head_desc),
        .i_pop        (pop)
    );

    apci_back #(
        .DELAY_READS (DELAY_READS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head_desc  (head_desc),
        .o_pop        (pop),
        .o_acc        (o_acc)
    );

    `APCI_ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !o_acc.valid, "output valid after reset")
    `APCI_ASSERT_RUN(a_err_shape, i_clk, i_rst_n, (o_acc.valid && o_acc.data.count_error) |-> (o_acc.data.last_access && o_acc.data.port_address == '0 && !o_acc.data.access_is_write), "malformed error transfer")
    `APCI_ASSERT_RUN(a_cmd_base_wr, i_clk, i_rst_n, (cfg_wr && paddr[3:2] == REG_CMD_BASE) |=> (r_cfg.cmd_base == $past(pwdata[15:0])), "command base write lost")
    `APCI_ASSERT_RUN(a_read_zero, i_clk, i_rst_n, (o_acc.valid && !o_acc.data.access_is_write) |-> (o_acc.data.byte_value == '0), "read access carries data")

endmodule

>>> sim/apci_taskfile_checker.sv
// checker: follows the config port, predicts the task file accesses of each request, compares
`timescale 1ns / 100ps

module apci_taskfile_checker import apci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    apci_req_if               i_req,
    apci_acc_if               i_acc,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                o_fail_count,
    output int                o_pending
);

    logic [15:0] cmd_base;
    logic [15:0] ctl_base;
    logic        nien;
    t_acc        expected_accesses[$];

    function automatic void queue_access(input logic [15:0] addr, input logic wr,
                                         input logic [7:0] val, input logic last);
        t_acc a;
        a.port_address = addr;
        a.access_is_write = wr;
        a.byte_value = val;
        a.last_access = last;
        a.count_error = 1'b0;
        expected_accesses.push_back(a);
    endfunction

    function automatic void plan_taskfile_accesses(input t_req r);
        t_acc        bad;
        logic        ext;
        logic [7:0]  sel;
        logic [7:0]  cmd;
        if (r.sector_count == 9'd0 || r.sector_count > MAX_COUNT) begin
            bad = '0;
            bad.last_access = 1'b1;
            bad.count_error = 1'b1;
            expected_accesses.push_back(bad);
            return;
        end
        ext = r.start_lba >= (48'd1 << LBA28_BITS);
        sel = r.drive_select ? SEL_SLAVE : SEL_MASTER;
        if (ext) begin
            queue_access(cmd_base + OFS_SEL, 1'b1, sel, 1'b0);
            queue_access(cmd_base + OFS_COUNT, 1'b1, {7'd0, r.sector_count[8]}, 1'b0);
            queue_access(cmd_base + OFS_LBA_L, 1'b1, r.start_lba[31:24], 1'b0);
            queue_access(cmd_base + OFS_LBA_M, 1'b1, r.start_lba[39:32], 1'b0);
            queue_access(cmd_base + OFS_LBA_H, 1'b1, r.start_lba[47:40], 1'b0);
            cmd = r.is_write ? CMD_WR48 : CMD_RD48;
        end else begin
            // lba bits 27..24 ride in the low nibble of the device select
            queue_access(cmd_base + OFS_SEL, 1'b1, sel | {4'h0, r.start_lba[27:24]}, 1'b0);
            cmd = r.is_write ? CMD_WR28 : CMD_RD28;
        end
        queue_access(cmd_base + OFS_COUNT, 1'b1, r.sector_count[7:0], 1'b0);
        queue_access(cmd_base + OFS_LBA_L, 1'b1, r.start_lba[7:0], 1'b0);
        queue_access(cmd_base + OFS_LBA_M, 1'b1, r.start_lba[15:8], 1'b0);
        queue_access(cmd_base + OFS_LBA_H, 1'b1, r.start_lba[23:16], 1'b0);
        queue_access(ctl_base, 1'b1, nien ? CTL_NIEN : CTL_IEN, 1'b0);
        for (int i = 0; i < DELAY_READS_DEF; i++)
            queue_access(ctl_base, 1'b0, 8'h00, 1'b0);
        queue_access(cmd_base + OFS_CMD, 1'b1, cmd, 1'b1);
    endfunction

    function automatic void note_field(input string field, input logic [15:0] exp_v,
                                       input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_v, act_v);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_acc exp_a;
        t_acc act_a;
        if (!i_rst_n) begin
            cmd_base = CMD_BASE_RST;
            ctl_base = CTL_BASE_RST;
            nien = 1'b0;
            expected_accesses.delete();
        end else begin
            if (i_acc.valid && i_acc.ready) begin
                act_a = i_acc.data;
                if (expected_accesses.size() == 0) begin
                    $display("%0t: unexpected access, expected none, actual addr 0x%0h data 0x%0h",
                             $time, act_a.port_address, act_a.byte_value);
                    o_fail_count++;
                end else begin
                    exp_a = expected_accesses.pop_front();
                    note_field("port_address", exp_a.port_address, act_a.port_address);
                    note_field("access_is_write", 16'(exp_a.access_is_write),
                               16'(act_a.access_is_write));
                    note_field("byte_value", 16'(exp_a.byte_value), 16'(act_a.byte_value));
                    note_field("last_access", 16'(exp_a.last_access), 16'(act_a.last_access));
                    note_field("count_error", 16'(exp_a.count_error), 16'(act_a.count_error));
                end
            end
            if (i_req.valid && i_req.ready)
                plan_taskfile_accesses(i_req.data);
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_AW-1:2])
                    REG_CMD_BASE: cmd_base = pwdata[15:0];
                    REG_CTL_BASE: ctl_base = pwdata[15:0];
                    REG_NIEN:     nien = pwdata[0];
                    default:      ;
                endcase
            end
        end
        o_pending = expected_accesses.size();
    end

endmodule

>>> sim/tb_ata_pio_command_issuer_unit.sv
// testbench top: clock, reset, request and config stimulus, verdict
`timescale 1ns / 100ps

module tb_ata_pio_command_issuer_unit;
    import apci_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                cycles = 0;
    bit                calm = 1'b0;

    apci_req_if req_ch ();
    apci_acc_if acc_ch ();

    ata_pio_command_issuer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_acc   (acc_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    apci_taskfile_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_acc        (acc_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // access sink: short random stalls, none during the calm stretch
    initial begin
        int hold = 0;
        acc_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                acc_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(99) < 3) begin
                hold = $urandom_range(0, 2);
                acc_ch.ready <= 1'b0;
            end else begin
                acc_ch.ready <= 1'b1;
            end
        end
    end

    function automatic t_req make_request(input logic drive, input logic [47:0] lba,
                                          input logic [8:0] count, input logic wr);
        t_req r;
        r.drive_select = drive;
        r.start_lba = lba;
        r.sector_count = count;
        r.is_write = wr;
        return r;
    endfunction

    function automatic t_req random_request();
        logic [47:0] lba;
        logic [8:0]  count;
        int          pick;
        lba = {16'($urandom()), 32'($urandom())};
        pick = $urandom_range(99);
        if (pick < 45)
            lba[47:28] = '0;
        else if (pick < 52)
            lba = (48'd1 << LBA28_BITS) - 48'd2 + 48'($urandom_range(0, 3));
        pick = $urandom_range(99);
        if (pick < 4)
            count = 9'd0;
        else if (pick < 9)
            count = 9'($urandom_range(257, 511));
        else if (pick < 15)
            count = MAX_COUNT;
        else
            count = 9'($urandom_range(1, 255));
        return make_request(1'($urandom()), lba, count, 1'($urandom()));
    endfunction

    // called and returns at a falling edge; valid stays high across back-to-back transfers
    task automatic issue_request(input t_req r);
        if (!calm && $urandom_range(99) < 6) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_accesses();
        req_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset config: field extremes, both lba modes, bad counts, count of 256
        issue_request(make_request(1'b0, 48'h0, 9'd1, 1'b0));
        issue_request(make_request(1'b1, 48'h0FFF_FFFF, 9'd256, 1'b1));
        issue_request(make_request(1'b0, 48'h1000_0000, 9'd256, 1'b0));
        issue_request(make_request(1'b1, 48'hFFFF_FFFF_FFFF, 9'd255, 1'b1));
        issue_request(make_request(1'b0, 48'h1234_5678_9ABC, 9'd0, 1'b1));
        issue_request(make_request(1'b1, 48'h00AB_CDEF, 9'd257, 1'b0));
        issue_request(make_request(1'b1, 48'hFFFF_FFFF_FFFF, 9'd511, 1'b1));
        issue_request(make_request(1'b0, 48'h0FFF_FFFF, 9'd1, 1'b1));
        issue_request(make_request(1'b1, 48'h1000_0000, 9'd1, 1'b0));
        issue_request(make_request(1'b0, 48'hAAAA_AAAA_AAAA, 9'd170, 1'b1));
        issue_request(make_request(1'b1, 48'h5555_5555_5555, 9'd85, 1'b0));
        issue_request(make_request(1'b1, 48'h0AAA_AAAA, 9'd128, 1'b0));
        issue_request(make_request(1'b0, 48'h0555_5555, 9'd127, 1'b1));
        issue_request(make_request(1'b0, 48'h8000_0000_0000, 9'd256, 1'b1));
        issue_request(make_request(1'b1, 48'h0, 9'd256, 1'b0));

        for (int ph = 0; ph < 4; ph++) begin
            drain_accesses();
            case (ph)
                0: begin
                    // top of the address space, +7 wraps past zero
                    write_register(REG_CMD_BASE, 32'h0000_FFFF);
                    write_register(REG_CTL_BASE, 32'h0000_FFFF);
                    write_register(REG_NIEN, 32'h1);
                end
                1: begin
                    write_register(REG_CMD_BASE, 32'h0);
                    write_register(REG_CTL_BASE, 32'h0);
                    write_register(REG_NIEN, 32'h0);
                end
                2: begin
                    write_register(REG_CMD_BASE, 32'($urandom_range(0, 65535)));
                    write_register(REG_CTL_BASE, 32'($urandom_range(0, 65535)));
                    write_register(REG_NIEN, 32'h1);
                end
                default: begin
                    // secondary channel
                    write_register(REG_CMD_BASE, 32'h0000_0170);
                    write_register(REG_CTL_BASE, 32'h0000_0376);
                    write_register(REG_NIEN, 32'($urandom_range(0, 1)));
                end
            endcase
            for (int n = 0; n < 104; n++) begin
                calm = (ph == 2 && n >= 20 && n < 85);
                if (ph == 1 && n == 50)
                    drain_accesses();
                issue_request(random_request());
            end
            calm = 1'b0;
        end
        drain_accesses();

        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
